>>> src/mosl_pkg.sv
// ----------------------------------------------------------------------------
// mosl_pkg
// Shared codes for the median of two sorted lists unit: input modes and
// result status codes, plus the data and median widths.
// ----------------------------------------------------------------------------
package mosl_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MED_W  = 33;

  typedef enum logic [1:0] {
    MODE_APPEND_FIRST  = 2'd0,
    MODE_APPEND_SECOND = 2'd1,
    MODE_COMPUTE       = 2'd2,
    MODE_NONE          = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NOPART   = 2'd3
  } status_t;

endpackage

>>> src/mosl_ram.sv
// ----------------------------------------------------------------------------
// mosl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mosl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

>>> src/median_of_two_sorted_lists_unit.sv
// ----------------------------------------------------------------------------
// median_of_two_sorted_lists_unit
// Appends words to two ascending lists and, on a compute word, binary-searches
// the partition of the shorter list to give twice the median with a status.
// Appends may follow back to back.
// A compute whose status is decided at once (overflow or empty) goes straight
// to the done state; otherwise each search step sets the cut, makes two reads
// through each list RAM's single read port, then compares, for at most
// floor(log2(shorter count + 1)) + 1 steps, until a partition or none is found.
// Synchronous reset clears the counts, the overflow flag, the sequencer and out_valid;
// list contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module median_of_two_sorted_lists_unit #(
  parameter int unsigned LIST_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] out_median_doubled,
  output logic [1:0]         out_status
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SW = CW + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MID  = 6'b000010,
    S_RDL  = 6'b000100,
    S_RDR  = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic          ovf_r, ovf_nxt;

  logic                 swap_r, swap_nxt;
  logic                 odd_r, odd_nxt;
  logic [CW-1:0]        na_r, na_nxt, nb_r, nb_nxt;
  logic signed [SW-1:0] half_r, half_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [SW-1:0] c1_r, c1_nxt, c2_r, c2_nxt;
  logic signed [31:0]   l1_r, l1_nxt, l2_r, l2_nxt;
  logic signed [32:0]   res_med_r, res_med_nxt;
  logic [1:0]           res_st_r, res_st_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [32:0]   out_med_r, out_med_nxt;
  logic [1:0]           out_st_r, out_st_nxt;

  logic          accept;
  logic          ram1_we, ram2_we;
  logic [AW-1:0] ram1_raddr, ram2_raddr, a_idx, b_idx;
  logic [31:0]   ram1_q, ram2_q;

  logic signed [SW-1:0] c1m1, c2m1, mid, na_s, nb_s;
  logic [CW:0]          total;
  logic signed [31:0]   r1, r2, q_a, q_b;
  logic                 hl1, hl2, hr1, hr2;
  logic signed [32:0]   left_w, right_w;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign ram1_we = accept && (in_mode == mosl_pkg::MODE_APPEND_FIRST) &&
                   (cnt1_r < CW'(LIST_DEPTH));
  assign ram2_we = accept && (in_mode == mosl_pkg::MODE_APPEND_SECOND) &&
                   (cnt2_r < CW'(LIST_DEPTH));

  // The search always works on list "a", the shorter one; swap_r maps it
  // onto the physical RAMs.
  assign c1m1  = c1_r - SW'(1);
  assign c2m1  = c2_r - SW'(1);
  assign a_idx = (state_r == S_RDL) ? c1m1[AW-1:0] : c1_r[AW-1:0];
  assign b_idx = (state_r == S_RDL) ? c2m1[AW-1:0] : c2_r[AW-1:0];
  assign ram1_raddr = swap_r ? b_idx : a_idx;
  assign ram2_raddr = swap_r ? a_idx : b_idx;
  assign q_a = swap_r ? $signed(ram2_q) : $signed(ram1_q);
  assign q_b = swap_r ? $signed(ram1_q) : $signed(ram2_q);

  assign na_s  = $signed({2'b00, na_r});
  assign nb_s  = $signed({2'b00, nb_r});
  assign total = {1'b0, cnt1_r} + {1'b0, cnt2_r};
  assign mid   = lo_r + ((hi_r - lo_r) >>> 1);

  assign r1  = q_a;
  assign r2  = q_b;
  assign hl1 = c1_r > SW'(0);
  assign hl2 = c2_r > SW'(0);
  assign hr1 = c1_r < na_s;
  assign hr2 = c2_r < nb_s;

  always_comb begin
    if (hr1 && hr2) begin
      right_w = (r1 < r2) ? 33'(r1) : 33'(r2);
    end else begin
      right_w = hr1 ? 33'(r1) : 33'(r2);
    end
    if (hl1 && hl2) begin
      left_w = (l1_r > l2_r) ? 33'(l1_r) : 33'(l2_r);
    end else begin
      left_w = hl1 ? 33'(l1_r) : 33'(l2_r);
    end
  end

  mosl_ram #(.WIDTH(mosl_pkg::DATA_W), .DEPTH(LIST_DEPTH)) u_ram1 (
    .clk     (clk),
    .wr_en   (ram1_we),
    .wr_addr (cnt1_r[AW-1:0]),
    .wr_data (in_value),
    .rd_addr (ram1_raddr),
    .rd_data (ram1_q)
  );

  mosl_ram #(.WIDTH(mosl_pkg::DATA_W), .DEPTH(LIST_DEPTH)) u_ram2 (
    .clk     (clk),
    .wr_en   (ram2_we),
    .wr_addr (cnt2_r[AW-1:0]),
    .wr_data (in_value),
    .rd_addr (ram2_raddr),
    .rd_data (ram2_q)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    ovf_nxt       = ovf_r;
    swap_nxt      = swap_r;
    odd_nxt       = odd_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    half_nxt      = half_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    res_med_nxt   = res_med_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_med_nxt   = out_med_r;
    out_st_nxt    = out_st_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            mosl_pkg::MODE_APPEND_FIRST: begin
              if (ram1_we) begin
                cnt1_nxt = cnt1_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            mosl_pkg::MODE_APPEND_SECOND: begin
              if (ram2_we) begin
                cnt2_nxt = cnt2_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            mosl_pkg::MODE_COMPUTE: begin
              swap_nxt    = cnt1_r > cnt2_r;
              na_nxt      = (cnt1_r > cnt2_r) ? cnt2_r : cnt1_r;
              nb_nxt      = (cnt1_r > cnt2_r) ? cnt1_r : cnt2_r;
              half_nxt    = $signed(SW'(total >> 1));
              odd_nxt     = total[0];
              lo_nxt      = '0;
              hi_nxt      = $signed({2'b00, ((cnt1_r > cnt2_r) ? cnt2_r : cnt1_r)});
              res_med_nxt = '0;
              cnt1_nxt    = '0;
              cnt2_nxt    = '0;
              ovf_nxt     = 1'b0;
              if (ovf_r) begin
                res_st_nxt = mosl_pkg::ST_OVERFLOW;
                state_nxt  = S_DONE;
              end else if (cnt1_r == '0 && cnt2_r == '0) begin
                res_st_nxt = mosl_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                res_st_nxt = mosl_pkg::ST_OK;
                state_nxt  = S_MID;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MID: begin
        if (lo_r > hi_r) begin
          res_st_nxt  = mosl_pkg::ST_NOPART;
          res_med_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          c1_nxt    = mid;
          c2_nxt    = half_r - mid;
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        state_nxt = S_RDR;
      end
      S_RDR: begin
        // The left neighbours read last cycle are on the RAM outputs now.
        l1_nxt    = q_a;
        l2_nxt    = q_b;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hl1 && hr2 && (l1_r > r2)) begin
          hi_nxt    = c1m1;
          state_nxt = S_MID;
        end else if (hl2 && hr1 && (l2_r > r1)) begin
          lo_nxt    = c1_r + SW'(1);
          state_nxt = S_MID;
        end else begin
          res_st_nxt  = mosl_pkg::ST_OK;
          res_med_nxt = odd_r ? (right_w <<< 1) : (left_w + right_w);
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = res_med_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    swap_r    <= swap_nxt;
    odd_r     <= odd_nxt;
    na_r      <= na_nxt;
    nb_r      <= nb_nxt;
    half_r    <= half_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    c1_r      <= c1_nxt;
    c2_r      <= c2_nxt;
    l1_r      <= l1_nxt;
    l2_r      <= l2_nxt;
    res_med_r <= res_med_nxt;
    res_st_r  <= res_st_nxt;
    out_med_r <= out_med_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_med_r;
  assign out_status         = out_st_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt1_r <= CW'(LIST_DEPTH)) && (cnt2_r <= CW'(LIST_DEPTH)))
    else $error("list count beyond depth");

  a_compute_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == mosl_pkg::MODE_COMPUTE) |=>
      (cnt1_r == '0) && (cnt2_r == '0) && !ovf_r)
    else $error("compute did not clear the lists");

  a_cut_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDL) |-> (c1_r >= SW'(0)) && (c1_r <= na_s) &&
      (c2_r >= SW'(0)) && (c2_r <= nb_s))
    else $error("partition outside the lists");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word not issued from the done state");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != mosl_pkg::ST_OK) |-> (out_med_r == '0))
    else $error("error status with non-zero median");

endmodule
